### design/u8cp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8cp_pkg
// shared types and byte/code constants for the utf-8 to code page decoder
// ----------------------------------------------------------------------------
package u8cp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C2,
        ST_C3,
        ST_E2,
        ST_E2_82,
        ST_DISCARD
    } t_dec_state;

    typedef struct packed {
        logic       valid;
        logic [6:0] code;
        logic       bad;
        logic       last;
    } t_res;

    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_TILDE   = 8'h7E;
    localparam logic [7:0] LEAD_C2      = 8'hC2;
    localparam logic [7:0] LEAD_C3      = 8'hC3;
    localparam logic [7:0] LEAD_E2      = 8'hE2;
    localparam logic [7:0] CONT_82      = 8'h82;
    localparam logic [7:0] CONT_AC      = 8'hAC;

    localparam logic [7:0] C3_A_UML     = 8'hA4;
    localparam logic [7:0] C3_A_UML_UP  = 8'h84;
    localparam logic [7:0] C3_O_UML     = 8'hB6;
    localparam logic [7:0] C3_O_UML_UP  = 8'h96;
    localparam logic [7:0] C3_U_UML     = 8'hBC;
    localparam logic [7:0] C3_U_UML_UP  = 8'h9C;
    localparam logic [7:0] C3_SHARP_S   = 8'h9F;
    localparam logic [7:0] C2_SECTION   = 8'hA7;
    localparam logic [7:0] C2_DEGREE    = 8'hB0;
    localparam logic [7:0] C2_SQUARE    = 8'hB2;
    localparam logic [7:0] C2_CUBE      = 8'hB3;
    localparam logic [7:0] C2_MICRO     = 8'hB5;

    localparam logic [6:0] CODE_ERROR   = 7'd0;
    localparam logic [6:0] CODE_A_UML   = 7'd6;
    localparam logic [6:0] CODE_A_UP    = 7'd7;
    localparam logic [6:0] CODE_O_UML   = 7'd8;
    localparam logic [6:0] CODE_O_UP    = 7'd11;
    localparam logic [6:0] CODE_U_UML   = 7'd12;
    localparam logic [6:0] CODE_U_UP    = 7'd13;
    localparam logic [6:0] CODE_SHARP_S = 7'd14;
    localparam logic [6:0] CODE_SECTION = 7'd15;
    localparam logic [6:0] CODE_DEGREE  = 7'd16;
    localparam logic [6:0] CODE_SQUARE  = 7'd17;
    localparam logic [6:0] CODE_CUBE    = 7'd18;
    localparam logic [6:0] CODE_EURO    = 7'd19;
    localparam logic [6:0] CODE_MICRO   = 7'd20;

endpackage
`default_nettype wire

### design/u8cp_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8cp_decode
// sequence state machine: holds pending lead bytes and the discard flag,
// matches one byte per enabled cycle and gives at most one result
// ----------------------------------------------------------------------------
module u8cp_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_fin,
    output u8cp_pkg::t_res     o_res
);

    u8cp_pkg::t_dec_state r_state;
    u8cp_pkg::t_dec_state n_state;

    logic       is_ascii;
    logic       c2_hit;
    logic       c3_hit;
    logic [6:0] c2_code;
    logic [6:0] c3_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8cp_pkg::ST_IDLE;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign is_ascii = ((i_byte >= u8cp_pkg::BYTE_SPACE) && (i_byte <= u8cp_pkg::BYTE_TILDE))
                   || (i_byte == u8cp_pkg::BYTE_TAB) || (i_byte == u8cp_pkg::BYTE_LF);

    always_comb begin
        c3_hit  = 1'b1;
        c3_code = u8cp_pkg::CODE_ERROR;
        unique case (i_byte)
            u8cp_pkg::C3_A_UML:    c3_code = u8cp_pkg::CODE_A_UML;
            u8cp_pkg::C3_A_UML_UP: c3_code = u8cp_pkg::CODE_A_UP;
            u8cp_pkg::C3_O_UML:    c3_code = u8cp_pkg::CODE_O_UML;
            u8cp_pkg::C3_O_UML_UP: c3_code = u8cp_pkg::CODE_O_UP;
            u8cp_pkg::C3_U_UML:    c3_code = u8cp_pkg::CODE_U_UML;
            u8cp_pkg::C3_U_UML_UP: c3_code = u8cp_pkg::CODE_U_UP;
            u8cp_pkg::C3_SHARP_S:  c3_code = u8cp_pkg::CODE_SHARP_S;
            default:               c3_hit  = 1'b0;
        endcase
    end

    always_comb begin
        c2_hit  = 1'b1;
        c2_code = u8cp_pkg::CODE_ERROR;
        unique case (i_byte)
            u8cp_pkg::C2_SECTION: c2_code = u8cp_pkg::CODE_SECTION;
            u8cp_pkg::C2_DEGREE:  c2_code = u8cp_pkg::CODE_DEGREE;
            u8cp_pkg::C2_SQUARE:  c2_code = u8cp_pkg::CODE_SQUARE;
            u8cp_pkg::C2_CUBE:    c2_code = u8cp_pkg::CODE_CUBE;
            u8cp_pkg::C2_MICRO:   c2_code = u8cp_pkg::CODE_MICRO;
            default:              c2_hit  = 1'b0;
        endcase
    end

    always_comb begin
        logic       err;
        logic       hit;
        logic [6:0] code;
        logic       hold;
        u8cp_pkg::t_dec_state hold_state;

        err        = 1'b0;
        hit        = 1'b0;
        code       = u8cp_pkg::CODE_ERROR;
        hold       = 1'b0;
        hold_state = u8cp_pkg::ST_IDLE;
        n_state    = r_state;

        unique case (r_state)
            u8cp_pkg::ST_DISCARD: begin
                if (i_fin) begin
                    n_state = u8cp_pkg::ST_IDLE;
                end
            end
            u8cp_pkg::ST_IDLE: begin
                if (is_ascii) begin
                    hit  = 1'b1;
                    code = i_byte[6:0];
                end else if (i_byte == u8cp_pkg::LEAD_C2) begin
                    hold       = 1'b1;
                    hold_state = u8cp_pkg::ST_C2;
                end else if (i_byte == u8cp_pkg::LEAD_C3) begin
                    hold       = 1'b1;
                    hold_state = u8cp_pkg::ST_C3;
                end else if (i_byte == u8cp_pkg::LEAD_E2) begin
                    hold       = 1'b1;
                    hold_state = u8cp_pkg::ST_E2;
                end else begin
                    err = 1'b1;
                end
            end
            u8cp_pkg::ST_C2: begin
                hit  = c2_hit;
                code = c2_code;
                err  = !c2_hit;
            end
            u8cp_pkg::ST_C3: begin
                hit  = c3_hit;
                code = c3_code;
                err  = !c3_hit;
            end
            u8cp_pkg::ST_E2: begin
                if (i_byte == u8cp_pkg::CONT_82) begin
                    hold       = 1'b1;
                    hold_state = u8cp_pkg::ST_E2_82;
                end else begin
                    err = 1'b1;
                end
            end
            u8cp_pkg::ST_E2_82: begin
                hit  = (i_byte == u8cp_pkg::CONT_AC);
                code = u8cp_pkg::CODE_EURO;
                err  = !hit;
            end
            default: begin
                n_state = u8cp_pkg::ST_IDLE;
            end
        endcase

        // a sequence cut off by the final byte is an error
        if (hold && i_fin) begin
            err  = 1'b1;
            hold = 1'b0;
        end

        o_res.valid = 1'b0;
        o_res.code  = u8cp_pkg::CODE_ERROR;
        o_res.bad   = 1'b0;
        o_res.last  = 1'b0;

        if (err) begin
            o_res.valid = 1'b1;
            o_res.bad   = 1'b1;
            o_res.last  = 1'b1;
            n_state     = i_fin ? u8cp_pkg::ST_IDLE : u8cp_pkg::ST_DISCARD;
        end else if (hit) begin
            o_res.valid = 1'b1;
            o_res.code  = code;
            o_res.last  = i_fin;
            n_state     = u8cp_pkg::ST_IDLE;
        end else if (hold) begin
            n_state = hold_state;
        end
    end

endmodule
`default_nettype wire

### design/utf8_to_codepage_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_codepage_decoder
// utf-8 byte stream to 7-bit internal character codes
// ----------------------------------------------------------------------------
// Takes one byte per clock unless stalled, gives one result word per complete
// character: printable ascii, tab and newline pass through, thirteen fixed two-
// and three-byte sequences map to codes 6..20. An unknown byte, a wrong
// continuation or a sequence cut off by the final byte gives one error word
// marked final, after which bytes are dropped up to the final byte. Each byte
// passes an input register and the matching state machine into a result
// register, so it is registered twice before its result is presented; the
// result register holds under a stall on the result side, and that stall holds
// the input once the input register is full.
// ----------------------------------------------------------------------------
module utf8_to_codepage_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [6:0]      o_char_code,
    output logic            o_bad_input,
    output logic            o_final_res
);

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_fin;
    logic           r_out_valid;
    logic [6:0]     r_out_code;
    logic           r_out_bad;
    logic           r_out_last;
    logic           out_blocked;
    logic           dec_en;
    u8cp_pkg::t_res dec_res;

    assign out_blocked = r_out_valid && i_stall;
    assign o_stall     = r_in_valid && out_blocked;
    assign dec_en      = r_in_valid && !out_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_fin  <= i_end_of_text;
        end
    end

    u8cp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (dec_en),
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .o_res   (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= dec_en && dec_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_en && dec_res.valid) begin
            r_out_code <= dec_res.code;
            r_out_bad  <= dec_res.bad;
            r_out_last <= dec_res.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_code;
    assign o_bad_input = r_out_bad;
    assign o_final_res = r_out_last;

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the utf-8 to code page decoder. A byte-level model
// of the decoder predicts each character word. A checker compares every word
// taken from the block with the oldest prediction. Directed texts cover
// pass-through ascii, special sequences and each way a text can be rejected.
// Random texts follow, made of mostly well-formed characters with some noise
// and broken sequences. Both sides idle and stall at random, with one stretch
// that runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [6:0] o_char_code;
    logic       o_bad_input;
    logic       o_final_res;

    // decoder model state
    logic [15:0] hold_bytes = 16'h0000;
    logic [1:0]  hold_count = 2'd0;
    logic        dropping = 1'b0;

    u8cp_pkg::t_res pending_chars[$];
    int   err_count = 0;
    int   quiet_cycles = 0;
    int   live_items = 0;
    logic no_gaps = 1'b0;

    utf8_to_codepage_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_code   (o_char_code),
        .o_bad_input   (o_bad_input),
        .o_final_res   (o_final_res)
    );

    always #5 i_clk = ~i_clk;

    // {hit, code} for a complete two-byte sequence
    function automatic logic [7:0] pair_code(input logic [7:0] lead, input logic [7:0] cont);
        case ({lead, cont})
            {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_A_UML}:
                pair_code = {1'b1, u8cp_pkg::CODE_A_UML};
            {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_A_UML_UP}:
                pair_code = {1'b1, u8cp_pkg::CODE_A_UP};
            {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_O_UML}:
                pair_code = {1'b1, u8cp_pkg::CODE_O_UML};
            {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_O_UML_UP}:
                pair_code = {1'b1, u8cp_pkg::CODE_O_UP};
            {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_U_UML}:
                pair_code = {1'b1, u8cp_pkg::CODE_U_UML};
            {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_U_UML_UP}:
                pair_code = {1'b1, u8cp_pkg::CODE_U_UP};
            {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_SHARP_S}:
                pair_code = {1'b1, u8cp_pkg::CODE_SHARP_S};
            {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_SECTION}:
                pair_code = {1'b1, u8cp_pkg::CODE_SECTION};
            {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_DEGREE}:
                pair_code = {1'b1, u8cp_pkg::CODE_DEGREE};
            {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_SQUARE}:
                pair_code = {1'b1, u8cp_pkg::CODE_SQUARE};
            {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_CUBE}:
                pair_code = {1'b1, u8cp_pkg::CODE_CUBE};
            {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_MICRO}:
                pair_code = {1'b1, u8cp_pkg::CODE_MICRO};
            default:
                pair_code = 8'h00;
        endcase
    endfunction

    // byte list of one special character, first byte in the top bits
    function automatic logic [23:0] special_bytes(input int idx);
        case (idx)
            0:       special_bytes = {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_A_UML, 8'h00};
            1:       special_bytes = {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_A_UML_UP, 8'h00};
            2:       special_bytes = {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_O_UML, 8'h00};
            3:       special_bytes = {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_O_UML_UP, 8'h00};
            4:       special_bytes = {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_U_UML, 8'h00};
            5:       special_bytes = {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_U_UML_UP, 8'h00};
            6:       special_bytes = {u8cp_pkg::LEAD_C3, u8cp_pkg::C3_SHARP_S, 8'h00};
            7:       special_bytes = {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_SECTION, 8'h00};
            8:       special_bytes = {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_DEGREE, 8'h00};
            9:       special_bytes = {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_SQUARE, 8'h00};
            10:      special_bytes = {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_CUBE, 8'h00};
            11:      special_bytes = {u8cp_pkg::LEAD_E2, u8cp_pkg::CONT_82, u8cp_pkg::CONT_AC};
            default: special_bytes = {u8cp_pkg::LEAD_C2, u8cp_pkg::C2_MICRO, 8'h00};
        endcase
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        u8cp_pkg::t_res res;
        logic [7:0]     hit;
        logic           grow;
        res = '0;
        res.valid = 1'b1;
        hit = 8'h00;
        grow = 1'b0;
        if (dropping) begin
            if (eot) begin
                dropping = 1'b0;
                hold_bytes = 16'h0000;
                hold_count = 2'd0;
            end
        end else if (hold_count == 2'd0 &&
                     ((b >= u8cp_pkg::BYTE_SPACE && b <= u8cp_pkg::BYTE_TILDE) ||
                      b == u8cp_pkg::BYTE_TAB || b == u8cp_pkg::BYTE_LF)) begin
            res.code = b[6:0];
            res.last = eot;
            pending_chars.push_back(res);
        end else begin
            case (hold_count)
                2'd0: begin
                    grow = (b == u8cp_pkg::LEAD_C2 || b == u8cp_pkg::LEAD_C3 ||
                            b == u8cp_pkg::LEAD_E2);
                end
                2'd1: begin
                    hit = pair_code(hold_bytes[7:0], b);
                    grow = (hold_bytes[7:0] == u8cp_pkg::LEAD_E2 && b == u8cp_pkg::CONT_82);
                end
                default: begin
                    if (hold_bytes == {u8cp_pkg::CONT_82, u8cp_pkg::LEAD_E2} &&
                        b == u8cp_pkg::CONT_AC)
                        hit = {1'b1, u8cp_pkg::CODE_EURO};
                end
            endcase
            if (hit[7]) begin
                hold_bytes = 16'h0000;
                hold_count = 2'd0;
                res.code = hit[6:0];
                res.last = eot;
                pending_chars.push_back(res);
            end else if (grow && !eot) begin
                if (hold_count == 2'd0)
                    hold_bytes = {8'h00, b};
                else
                    hold_bytes[15:8] = b;
                hold_count = hold_count + 2'd1;
            end else begin
                hold_bytes = 16'h0000;
                hold_count = 2'd0;
                dropping = !eot;
                res.code = u8cp_pkg::CODE_ERROR;
                res.bad = 1'b1;
                res.last = 1'b1;
                pending_chars.push_back(res);
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eot);
        while (!no_gaps && $urandom_range(0, 99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        live_items++;
        decode_byte(b, eot);
    endtask

    task automatic push_special(input int idx, input int cut_len, input logic eot);
        logic [23:0] seq_bytes;
        int          k;
        seq_bytes = special_bytes(idx);
        for (k = 0; k < cut_len; k++)
            push_byte(seq_bytes[23 - 8 * k -: 8], eot && k == cut_len - 1);
    endtask

    task automatic test_plain_text();
        push_byte(u8cp_pkg::BYTE_SPACE, 1'b0);
        push_byte(u8cp_pkg::BYTE_TILDE, 1'b0);
        push_byte(u8cp_pkg::BYTE_TAB, 1'b0);
        push_byte(u8cp_pkg::BYTE_LF, 1'b1);
    endtask

    task automatic test_special_chars();
        push_special(0, 2, 1'b0);
        push_special(12, 2, 1'b0);
        push_special(11, 3, 1'b1);
    endtask

    task automatic test_bad_sequences();
        // unknown byte, rest of text dropped
        push_byte(8'hFF, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h41, 1'b1);
        // ascii where a continuation belongs
        push_byte(u8cp_pkg::LEAD_C3, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(u8cp_pkg::BYTE_SPACE, 1'b1);
        // sequences cut off by the final byte
        push_byte(u8cp_pkg::LEAD_C2, 1'b1);
        push_special(11, 2, 1'b1);
        // wrong second byte of the euro sign
        push_byte(u8cp_pkg::LEAD_E2, 1'b0);
        push_byte(u8cp_pkg::CONT_AC, 1'b0);
        push_byte(8'h00, 1'b1);
        // unknown bytes on the final byte
        push_byte(8'h00, 1'b1);
        push_byte(8'h80, 1'b1);
        push_byte(8'h7F, 1'b1);
    endtask

    task automatic test_random_text();
        int         text_len;
        int         c;
        int         roll;
        int         idx;
        logic       eot;
        logic [7:0] ch;
        while (live_items < RANDOM_ITEMS) begin
            no_gaps = (live_items >= 400 && live_items < 600);
            text_len = $urandom_range(1, 12);
            for (c = 0; c < text_len; c++) begin
                eot = (c == text_len - 1);
                roll = $urandom_range(0, 99);
                idx = $urandom_range(0, 12);
                if (roll < 50) begin
                    if ($urandom_range(0, 9) == 0)
                        ch = $urandom_range(0, 1) ? u8cp_pkg::BYTE_TAB : u8cp_pkg::BYTE_LF;
                    else
                        ch = 8'($urandom_range(u8cp_pkg::BYTE_SPACE, u8cp_pkg::BYTE_TILDE));
                    push_byte(ch, eot);
                end else if (roll < 88) begin
                    push_special(idx, idx == 11 ? 3 : 2, eot);
                end else if (roll < 94) begin
                    push_byte(8'($urandom_range(0, 255)), eot);
                end else begin
                    // broken sequence: cut short, then maybe a stray byte
                    push_special(idx, idx == 11 ? int'($urandom_range(1, 2)) : 1, eot);
                    if (!eot)
                        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        u8cp_pkg::t_res want;
        logic           took;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            took = i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                took = 1'b1;
                if (pending_chars.size() == 0) begin
                    $error("unexpected word: char_code %0d bad_input %0d final_res %0d",
                           o_char_code, o_bad_input, o_final_res);
                    err_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_char_code !== want.code) begin
                        $error("char_code: expected %0d, got %0d", want.code, o_char_code);
                        err_count++;
                    end
                    if (o_bad_input !== want.bad) begin
                        $error("bad_input: expected %0d, got %0d", want.bad, o_bad_input);
                        err_count++;
                    end
                    if (o_final_res !== want.last) begin
                        $error("final_res: expected %0d, got %0d", want.last, o_final_res);
                        err_count++;
                    end
                end
            end
            quiet_cycles <= took ? 0 : quiet_cycles + 1;
            i_stall <= !no_gaps && ($urandom_range(0, 99) < 32);
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_text();
        test_special_chars();
        test_bad_sequences();
        test_random_text();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/u8cp_pkg.sv
design/u8cp_decode.sv
design/utf8_to_codepage_decoder.sv
sim/tb_top.sv
